// File: src/b64d_pkg.sv
// Shared types, constants and the base64url alphabet lookup for the stream decoder.
`default_nettype none

package b64d_pkg;

    // Default width of the per-string byte counter
    localparam int COUNT_BITS_DEF = 16;

    // Depth of the queue between classifier and executor
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int SYM_W   = 8;
    localparam int SEXT_W  = 6;
    localparam int CAP_W   = 16;
    localparam int BCNT_W  = 16;
    localparam int TDATA_W = 24;
    localparam int TUSER_W = 2;

    localparam logic [CAP_W-1:0]  CAP_RESET = 16'hFFFF;
    localparam logic [SYM_W-1:0]  PAD_CHAR  = 8'h3D;

    // tuser bit positions on the result side
    localparam int TUSER_BYTE_VALID = 0;
    localparam int TUSER_ERROR      = 1;

    // Class of one incoming character
    typedef enum logic [1:0] {
        SYM_DATA,
        SYM_PAD,
        SYM_BAD
    } sym_kind_t;

    // Classified character as it travels through the queue
    typedef struct packed {
        sym_kind_t           kind;
        logic [SEXT_W-1:0]   sextet;
        logic                last;
    } b64d_item_t;

    // Map one character to its class and sextet value
    function automatic b64d_item_t classify(input logic [SYM_W-1:0] c, input logic last);
        b64d_item_t it;
        it.last   = last;
        it.kind   = SYM_DATA;
        it.sextet = '0;
        if (c == PAD_CHAR) begin
            it.kind = SYM_PAD;
        end
        else if (c inside {[8'h41:8'h5A]}) begin
            it.sextet = SEXT_W'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7A]}) begin
            it.sextet = SEXT_W'(c - 8'h61 + 8'd26);
        end
        else if (c inside {[8'h30:8'h39]}) begin
            it.sextet = SEXT_W'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2D) begin
            it.sextet = 6'd62;
        end
        else if (c == 8'h5F) begin
            it.sextet = 6'd63;
        end
        else begin
            it.kind = SYM_BAD;
        end
        return it;
    endfunction

endpackage

`default_nettype wire

// File: src/b64d_front.sv
// Input side: accepts characters and classifies them into queue entries.
`default_nettype none

module b64d_front (
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [b64d_pkg::SYM_W-1:0] s_axis_tdata,
    input  wire logic                      s_axis_tlast,
    input  wire logic                      q_full,
    output logic                           q_push,
    output b64d_pkg::b64d_item_t           q_item
);
    import b64d_pkg::*;

    // Take a character whenever the queue has room
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // Classify the character on its way in
    assign q_item = classify(s_axis_tdata, s_axis_tlast);

endmodule

`default_nettype wire

// File: src/b64d_queue.sv
// Short queue of classified characters between the front and back parts.
`default_nettype none

module b64d_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire b64d_pkg::b64d_item_t push_item,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output b64d_pkg::b64d_item_t      head
);
    import b64d_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    b64d_item_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: src/b64d_back.sv
// Execution side: group tracking, byte assembly, error and count state, result register.
`default_nettype none

module b64d_back #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [b64d_pkg::CAP_W-1:0]    cfg_data,
    input  wire logic                          q_not_empty,
    input  wire b64d_pkg::b64d_item_t          q_head,
    output logic                               q_pop,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [b64d_pkg::TDATA_W-1:0]       m_axis_tdata,
    output logic [b64d_pkg::TUSER_W-1:0]       m_axis_tuser,
    output logic                               m_axis_tlast
);
    import b64d_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

    logic [CAP_W-1:0]      cap_reg;
    logic [1:0]            gpos_reg, gpos_next;
    logic [SEXT_W-1:0]     prev_reg, prev_next;
    logic                  pad_reg, pad_next;
    logic                  err_reg, err_next;
    logic [COUNT_BITS-1:0] bytes_reg, bytes_next;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  byte_valid_reg, byte_valid_next;
    logic                  done_reg, done_next;
    logic                  out_err_reg, out_err_next;
    logic [BCNT_W-1:0]     bcnt_reg, bcnt_next;

    logic                  emit;
    logic [7:0]            byte_val;
    logic [CMP_W-1:0]      bytes_ext;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      bytes_next_ext;

    assign bytes_ext      = CMP_W'(bytes_reg);
    assign cap_ext        = CMP_W'(cap_reg);
    assign bytes_next_ext = CMP_W'(bytes_next);

    // Pop one entry whenever the result register is free or being drained
    assign q_pop = q_not_empty && (!out_valid_reg || m_axis_tready);

    // Assemble the byte from the previous and current sextets
    always_comb
    begin
        case (gpos_reg)
            2'd1:    byte_val = {prev_reg, q_head.sextet[5:4]};
            2'd2:    byte_val = {prev_reg[3:0], q_head.sextet[5:2]};
            2'd3:    byte_val = {prev_reg[1:0], q_head.sextet};
            default: byte_val = '0;
        endcase
    end

    // Update string state for the popped character
    always_comb
    begin
        gpos_next  = gpos_reg;
        prev_next  = prev_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        bytes_next = bytes_reg;
        emit       = 1'b0;
        if (q_pop) begin
            if (q_head.kind == SYM_PAD) begin
                pad_next = 1'b1;
            end
            else if (pad_reg || q_head.kind == SYM_BAD) begin
                err_next = 1'b1;
            end
            else begin
                prev_next = q_head.sextet;
                gpos_next = gpos_reg + 2'd1;
                if (gpos_reg != 2'd0 && !err_reg) begin
                    if (bytes_ext >= cap_ext) begin
                        err_next = 1'b1;
                    end
                    else begin
                        emit = 1'b1;
                        if (bytes_reg != '1) begin
                            bytes_next = bytes_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Build the next result and hold it while the receiver stalls
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        done_next       = done_reg;
        out_err_next    = out_err_reg;
        bcnt_next       = bcnt_reg;
        if (q_pop && (emit || q_head.last)) begin
            out_valid_next  = 1'b1;
            out_byte_next   = emit ? byte_val : '0;
            byte_valid_next = emit;
            done_next       = q_head.last;
            out_err_next    = q_head.last && (err_next || gpos_next == 2'd1);
            bcnt_next       = '0;
            if (q_head.last) begin
                bcnt_next = (bytes_next_ext > CMP_W'({BCNT_W{1'b1}})) ? {BCNT_W{1'b1}}
                                                                        : bytes_next_ext[BCNT_W-1:0];
            end
        end
    end

    // Control and string state; clear the string after its last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg       <= CAP_RESET;
            gpos_reg      <= '0;
            prev_reg      <= '0;
            pad_reg       <= 1'b0;
            err_reg       <= 1'b0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
            if (q_pop && q_head.last) begin
                gpos_reg  <= '0;
                prev_reg  <= '0;
                pad_reg   <= 1'b0;
                err_reg   <= 1'b0;
                bytes_reg <= '0;
            end
            else begin
                gpos_reg  <= gpos_next;
                prev_reg  <= prev_next;
                pad_reg   <= pad_next;
                err_reg   <= err_next;
                bytes_reg <= bytes_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        done_reg       <= done_next;
        out_err_reg    <= out_err_next;
        bcnt_reg       <= bcnt_next;
    end

    assign m_axis_tvalid                  = out_valid_reg;
    assign m_axis_tdata                   = {bcnt_reg, out_byte_reg};
    assign m_axis_tuser[TUSER_BYTE_VALID] = byte_valid_reg;
    assign m_axis_tuser[TUSER_ERROR]      = out_err_reg;
    assign m_axis_tlast                   = done_reg;

endmodule

`default_nettype wire

// File: src/base64url_stream_decoder_core.sv
// Top level of the base64url stream decoder: front classifier, queue and executor.
//
// Usage:
//   s_axis carries one ASCII character per transaction; s_axis_tlast marks the
//   final character of a string. m_axis carries at most one result per
//   character: a decoded byte (tuser bit 0 set) on the 2nd, 3rd and 4th
//   character of each group, and on the last character a closing result with
//   tlast set, the error flag in tuser bit 1 and the byte count in tdata.
//   cfg_valid/cfg_data write the byte capacity per string; cfg_ready is always
//   high; the user must make writes only while no string is in flight, and the
//   block itself does not enforce this. An accepted character is written into
//   the queue, and its result is then registered in the result register.
//   Throughput: one character per cycle while the receiver takes results; the
//   sextet lookup in the front is combinational. Reset clears the queue, the
//   string state and the result valid flag and sets the capacity to 65535. When
//   the receiver stalls, the result is held in its register; the two-entry
//   queue keeps taking characters until it fills, then s_axis_tready drops.
`default_nettype none

module base64url_stream_decoder_core #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Configuration write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [b64d_pkg::CAP_W-1:0]     cfg_data,      // out_capacity
    // Character input
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [b64d_pkg::SYM_W-1:0]     s_axis_tdata,  // [7:0] symbol
    input  wire logic                           s_axis_tlast,  // last
    // Result output
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [b64d_pkg::TDATA_W-1:0]        m_axis_tdata,  // [7:0] out_byte, [23:8] byte_count
    output logic [b64d_pkg::TUSER_W-1:0]        m_axis_tuser,  // [0] byte_valid, [1] error
    output logic                                m_axis_tlast   // done_res
);
    import b64d_pkg::*;

    b64d_item_t push_item;
    b64d_item_t head_item;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;

    assign cfg_ready = 1'b1;

    b64d_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    b64d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_item)
    );

    b64d_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .q_not_empty   (q_not_empty),
        .q_head        (head_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the base64url stream decoder core.
`timescale 1ns / 1ps

module tb_top;
    import b64d_pkg::*;

    localparam int STALL_LIMIT  = 4000;  // quiet cycles before the watchdog trips
    localparam int LONG_HOLD    = 400;   // receiver hold-off that fills the block
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result

    // One expected result of the decoder
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done;
        logic        error;
        logic [15:0] byte_count;
    } dec_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [SYM_W-1:0]     s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [TUSER_W-1:0]   m_axis_tuser;
    logic                 m_axis_tlast;

    // Decoder state as the bench tracks it
    logic [15:0] capacity_model = 16'hFFFF;
    logic [1:0]  grp_pos_m = '0;
    logic [5:0]  prev_sext_m = '0;
    logic        pad_seen_m = 1'b0;
    logic        err_m = 1'b0;
    logic [15:0] nbytes_m = '0;

    dec_result_t decoded_queue[$];
    logic [7:0]  str_buf[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          hold_request = 1'b0;

    base64url_stream_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // Map a character to its class and sextet
    function automatic sym_kind_t char_class(input logic [7:0] c, output logic [5:0] sx);
        sx = '0;
        if (c == PAD_CHAR)
            return SYM_PAD;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            sx = 6'(c - 8'h41);
            return SYM_DATA;
        end
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            sx = 6'(c - 8'h61 + 8'd26);
            return SYM_DATA;
        end
        if (c >= 8'h30 && c <= 8'h39)
        begin
            sx = 6'(c - 8'h30 + 8'd52);
            return SYM_DATA;
        end
        if (c == 8'h2D)
        begin
            sx = 6'd62;
            return SYM_DATA;
        end
        if (c == 8'h5F)
        begin
            sx = 6'd63;
            return SYM_DATA;
        end
        return SYM_BAD;
    endfunction

    // Encode a sextet value as its alphabet character
    function automatic logic [7:0] alphabet_char(input int unsigned v);
        if (v < 26)
            return 8'(65 + v);
        if (v < 52)
            return 8'(97 + v - 26);
        if (v < 62)
            return 8'(48 + v - 52);
        if (v == 62)
            return 8'h2D;
        return 8'h5F;
    endfunction

    // Advance the tracked state by one character and queue the result it causes
    task automatic decode_char(input logic [7:0] sym, input logic last);
        logic [5:0]  sx;
        sym_kind_t   kind;
        logic        emit;
        logic [7:0]  b;
        dec_result_t r;
        emit = 1'b0;
        b = '0;
        kind = char_class(sym, sx);
        if (kind == SYM_PAD)
            pad_seen_m = 1'b1;
        else if (pad_seen_m || kind == SYM_BAD)
            err_m = 1'b1;
        else
        begin
            case (grp_pos_m)
                2'd1: b = {prev_sext_m, sx[5:4]};
                2'd2: b = {prev_sext_m[3:0], sx[5:2]};
                2'd3: b = {prev_sext_m[1:0], sx};
                default: b = '0;
            endcase
            // Bytes come from positions 1..3, only while no error is pending
            if (grp_pos_m != 2'd0 && !err_m)
            begin
                if (nbytes_m >= capacity_model)
                    err_m = 1'b1;
                else
                begin
                    emit = 1'b1;
                    if (nbytes_m != 16'hFFFF)
                        nbytes_m = nbytes_m + 16'd1;
                end
            end
            prev_sext_m = sx;
            grp_pos_m = grp_pos_m + 2'd1;
        end
        if (emit || last)
        begin
            r.out_byte   = emit ? b : 8'h00;
            r.byte_valid = emit;
            r.done       = last;
            r.error      = last && (err_m || grp_pos_m == 2'd1);
            r.byte_count = last ? nbytes_m : 16'h0000;
            decoded_queue.push_back(r);
            // Close the string
            if (last)
            begin
                grp_pos_m = '0;
                prev_sext_m = '0;
                pad_seen_m = 1'b0;
                err_m = 1'b0;
                nbytes_m = '0;
            end
        end
    endtask

    // Track every transaction and check each result against the oldest expectation
    always @(posedge clk)
    begin : monitor
        dec_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                capacity_model = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_queue.size() == 0)
                begin
                    $error("unexpected result: tdata %h tuser %b tlast %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = decoded_queue.pop_front();
                    if (m_axis_tdata[7:0] !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_axis_tuser[TUSER_BYTE_VALID] !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %b, got %b", want.byte_valid,
                               m_axis_tuser[TUSER_BYTE_VALID]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.done)
                    begin
                        $error("done_res: expected %b, got %b", want.done, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tuser[TUSER_ERROR] !== want.error)
                    begin
                        $error("error: expected %b, got %b", want.error,
                               m_axis_tuser[TUSER_ERROR]);
                        fail_count++;
                    end
                    if (m_axis_tdata[23:8] !== want.byte_count)
                    begin
                        $error("byte_count: expected %0d, got %0d", want.byte_count,
                               m_axis_tdata[23:8]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_char(s_axis_tdata, s_axis_tlast);
        end
    end

    // Receiver: stall in changing patterns, plus a long hold-off on request
    initial
    begin : receiver
        int  mode;
        int  mode_left;
        int  hold_left;
        int  phase;
        bit  ready_next;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case (mode)
                    0: ready_next = 1'b1;
                    1: ready_next = $urandom_range(0, 1);
                    2: ready_next = (phase % 5) >= 2;
                    default: ready_next = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_axis_tready <= ready_next;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // Offer one character in bursts with random gaps; return once it is accepted
    task automatic send_char(input logic [7:0] sym, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Send the buffered string, marking its final character
    task automatic send_buffer();
        for (int i = 0; i < str_buf.size(); i++)
            send_char(str_buf[i], i == str_buf.size() - 1);
    endtask

    task automatic send_text(input string txt);
        str_buf.delete();
        foreach (txt[i])
            str_buf.push_back(txt[i]);
        send_buffer();
    endtask

    // Stop offering and wait until every expected result has arrived
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (decoded_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed strings, some noise and some broken ones
    task automatic build_random_string();
        int         kind;
        int         n;
        int         pads;
        logic [7:0] c;
        str_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0: c = 8'($urandom_range(0, 255));
                    1: c = PAD_CHAR;
                    default: c = alphabet_char($urandom_range(0, 63));
                endcase
                str_buf.push_back(c);
            end
        end
        else
        begin
            n = 4 * $urandom_range(0, 5);
            case ($urandom_range(0, 2))
                1: n += 2;
                2: n += 3;
                default: n += 0;
            endcase
            repeat (n) str_buf.push_back(alphabet_char($urandom_range(0, 63)));
            pads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : (4 - n % 4) % 4;
            repeat (pads) str_buf.push_back(PAD_CHAR);
            if (str_buf.size() == 0)
                str_buf.push_back(alphabet_char($urandom_range(0, 63)));
            // Corrupt a share of them
            if (kind >= 85)
            begin
                case ($urandom_range(0, 2))
                    0: str_buf.insert($urandom_range(0, str_buf.size() - 1),
                                      8'($urandom_range(0, 255)));
                    1:
                    begin
                        str_buf.push_back(PAD_CHAR);
                        str_buf.push_back(alphabet_char($urandom_range(0, 63)));
                    end
                    default: str_buf.push_back(alphabet_char($urandom_range(0, 63)));
                endcase
            end
        end
    endtask

    // Alphabet boundaries, all-zero and all-one sextets
    task automatic test_alphabet_edges();
        send_text("AZaz");
        send_text("09-_");
    endtask

    // Canonical padding, data after padding, final group of one ending in padding
    task automatic test_padding();
        send_text("QQ==");
        send_text("QQ=A");
        send_text("_=");
    endtask

    // Invalid characters at both ends of the byte range
    task automatic test_bad_chars();
        str_buf = {8'h51, 8'h00, 8'h51, 8'hFF};
        send_buffer();
    endtask

    // Zero and one byte of capacity, then restore the maximum
    task automatic test_capacity_limits();
        drain_results();
        write_capacity(16'h0000);
        send_text("AAAA");
        drain_results();
        write_capacity(16'h0001);
        send_text("AAA");
        drain_results();
        write_capacity(16'hFFFF);
    endtask

    task automatic test_random_strings(input logic [15:0] cap, input int n_items);
        int start;
        drain_results();
        write_capacity(cap);
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            build_random_string();
            send_buffer();
        end
    endtask

    // Hold off the receiver long enough that the block stalls its input
    task automatic test_output_backpressure();
        int start;
        hold_request = 1'b1;
        start = items_sent;
        while (items_sent - start < 60)
        begin
            build_random_string();
            send_buffer();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_alphabet_edges();
        test_padding();
        test_bad_chars();
        test_capacity_limits();
        test_random_strings(16'hFFFF, 600);
        test_random_strings(16'($urandom_range(0, 24)), 300);
        test_random_strings(16'(16'h8000 + $urandom_range(0, 32767)), 250);
        test_random_strings(16'($urandom_range(1, 8)), 250);
        test_output_backpressure();
        test_random_strings(16'hFFFF, 300);
        drain_results();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
